@@ src/wsmc_pkg.sv @@
// Shared types, constants and helpers for the watch setting-mode controller.
package wsmc_pkg;

  localparam int unsigned CorrW    = 5;
  localparam int unsigned TiltW    = 8;
  localparam int unsigned ThW      = 15;
  localparam int unsigned LimW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [CorrW-1:0] CorrMax    = 5'd30;
  localparam logic [CorrW-1:0] DayCorrMax = 5'd24;

  localparam logic [ThW-1:0]  FlipThRst  = 15'd7000;
  localparam logic [ThW-1:0]  TiltThRst  = 15'd1024;
  localparam logic [LimW-1:0] TiltLimRst = 7'd50;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFlipTh  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTiltTh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTiltLim = 2'd2;

  // Screen codes as reported on the result.
  localparam logic [3:0] ScrFade  = 4'd0;
  localparam logic [3:0] ScrTime  = 4'd1;
  localparam logic [3:0] ScrHour  = 4'd2;
  localparam logic [3:0] ScrMin   = 4'd3;
  localparam logic [3:0] ScrDeb   = 4'd4;
  localparam logic [3:0] ScrCMin  = 4'd5;
  localparam logic [3:0] ScrCHour = 4'd6;
  localparam logic [3:0] ScrCDay  = 4'd7;
  localparam logic [3:0] ScrCMon  = 4'd8;
  localparam logic [3:0] ScrEmpty = 4'd9;

  typedef enum logic [8:0] {
    ModeFade  = 9'b000000001,
    ModeTime  = 9'b000000010,
    ModeHour  = 9'b000000100,
    ModeMin   = 9'b000001000,
    ModeDeb   = 9'b000010000,
    ModeCMin  = 9'b000100000,
    ModeCHour = 9'b001000000,
    ModeCDay  = 9'b010000000,
    ModeCMon  = 9'b100000000
  } mode_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhFlip  = 3'b010,
    PhArmed = 3'b100
  } phase_e;

  typedef struct packed {
    logic              req_type;
    logic              woken;
    logic              right_edge;
    logic              left_edge;
    logic              right_held;
    logic              left_held;
    logic              tap;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        screen;
    logic [CorrW-1:0]  shown_value;
    logic signed [2:0] hour_change;
    logic signed [2:0] minute_change;
    logic              prolong_short;
    logic              prolong_long;
    logic              prolong_very_long;
    logic              acted;
  } out_item_t;

  typedef struct packed {
    mode_e                        mode;
    logic                         input_enabled;
    phase_e                       phase;
    logic signed [TiltW-1:0]      tilt_count;
    logic [3:0][CorrW-1:0]        corr;
  } state_t;

  typedef struct packed {
    logic [ThW-1:0]  flip_th;
    logic [ThW-1:0]  tilt_th;
    logic [LimW-1:0] tilt_lim;
  } cfg_t;

  function automatic logic [3:0] screen_code(mode_e m);
    logic [3:0] s;
    case (m)
      ModeFade:  s = ScrFade;
      ModeTime:  s = ScrTime;
      ModeHour:  s = ScrHour;
      ModeMin:   s = ScrMin;
      ModeDeb:   s = ScrDeb;
      ModeCMin:  s = ScrCMin;
      ModeCHour: s = ScrCHour;
      ModeCDay:  s = ScrCDay;
      ModeCMon:  s = ScrCMon;
      default:   s = ScrEmpty;
    endcase
    return s;
  endfunction

endpackage

@@ src/wsmc_step.sv @@
// One step of the mode machine: next state and result for a single item.
module wsmc_step (
  input  wsmc_pkg::in_item_t  item_i,
  input  wsmc_pkg::state_t    state_i,
  input  wsmc_pkg::cfg_t      cfg_i,
  output wsmc_pkg::state_t    state_o,
  output wsmc_pkg::out_item_t res_o
);

  // Accelerometer compares, all in 17-bit signed arithmetic.
  logic signed [16:0] z_ext, fth_ext, y_neg, tth_ext;
  logic               z_down, z_up;
  // The count is worked one bit wider so that it cannot wrap before the limit fires.
  logic signed [wsmc_pkg::TiltW:0]   tilt_cur, tilt_tmp, lim_ext;
  logic signed [wsmc_pkg::TiltW-1:0] tilt_next;
  logic                              fire_up, fire_dn;
  logic signed [2:0]                 tilt_step;

  always_comb begin
    z_ext   = {item_i.accel_z[15], item_i.accel_z};
    fth_ext = {2'b00, cfg_i.flip_th};
    z_down  = z_ext < -fth_ext;
    z_up    = z_ext > fth_ext;

    // Negated Y saturates at the top of the 16-bit range.
    if (item_i.accel_y == 16'sh8000) begin
      y_neg = 17'sd32767;
    end else begin
      y_neg = -{item_i.accel_y[15], item_i.accel_y};
    end
    tth_ext  = {2'b00, cfg_i.tilt_th};
    tilt_cur = {state_i.tilt_count[wsmc_pkg::TiltW-1], state_i.tilt_count};
    if (y_neg > tth_ext) begin
      tilt_tmp = tilt_cur + 9'sd1;
    end else if (y_neg < -tth_ext) begin
      tilt_tmp = tilt_cur - 9'sd1;
    end else begin
      tilt_tmp = '0;
    end
    lim_ext   = {2'b00, cfg_i.tilt_lim};
    fire_up   = tilt_tmp > lim_ext;
    fire_dn   = tilt_tmp < -lim_ext;
    tilt_next = (fire_up || fire_dn) ? '0 : tilt_tmp[wsmc_pkg::TiltW-1:0];
    tilt_step = fire_up ? 3'sd1 : (fire_dn ? -3'sd1 : 3'sd0);
  end

  // Correction edit for the value selected by the current screen.
  logic [1:0]                 corr_idx;
  logic [wsmc_pkg::CorrW-1:0] corr_cur, corr_max, corr_mid, corr_new;
  logic                       both_held, adv_right, corr_adv;

  always_comb begin
    case (state_i.mode)
      wsmc_pkg::ModeCHour: corr_idx = 2'd1;
      wsmc_pkg::ModeCDay:  corr_idx = 2'd2;
      wsmc_pkg::ModeCMon:  corr_idx = 2'd3;
      default:             corr_idx = 2'd0;
    endcase
    corr_cur  = state_i.corr[corr_idx];
    corr_max  = (corr_idx == 2'd2) ? wsmc_pkg::DayCorrMax : wsmc_pkg::CorrMax;
    both_held = item_i.right_held && item_i.left_held;

    corr_mid = corr_cur;
    if (item_i.right_edge) begin
      corr_mid = (corr_cur == '0) ? corr_max : corr_cur - 5'd1;
    end
    adv_right = item_i.right_edge && both_held;
    corr_new  = corr_mid;
    if (item_i.left_edge && !adv_right) begin
      corr_new = (corr_mid == corr_max) ? '0 : corr_mid + 5'd1;
    end
    corr_adv = adv_right || (item_i.left_edge && both_held);
  end

  // Mode machine.
  wsmc_pkg::mode_e mode_cur;
  logic            enabled, wake_short, any_held;

  always_comb begin
    state_o  = state_i;
    res_o    = '0;
    res_o.screen = wsmc_pkg::ScrEmpty;
    mode_cur   = state_i.mode;
    enabled    = state_i.input_enabled;
    wake_short = 1'b0;
    any_held   = item_i.right_held || item_i.left_held;

    if (item_i.req_type) begin
      state_o.mode          = wsmc_pkg::ModeFade;
      state_o.input_enabled = 1'b0;
      state_o.phase         = wsmc_pkg::PhIdle;
      res_o.acted           = 1'b1;
    end else if (item_i.woken) begin
      res_o.acted  = 1'b1;
      res_o.screen = wsmc_pkg::screen_code(state_i.mode);
      if (state_i.mode == wsmc_pkg::ModeCMin || state_i.mode == wsmc_pkg::ModeCHour ||
          state_i.mode == wsmc_pkg::ModeCDay || state_i.mode == wsmc_pkg::ModeCMon) begin
        res_o.shown_value = corr_cur;
      end

      if (state_i.mode == wsmc_pkg::ModeFade) begin
        mode_cur            = wsmc_pkg::ModeTime;
        res_o.prolong_short = 1'b1;
      end
      enabled               = state_i.input_enabled || !any_held;
      state_o.input_enabled = enabled;
      state_o.mode          = mode_cur;

      if (enabled) begin
        case (mode_cur)
          wsmc_pkg::ModeTime, wsmc_pkg::ModeDeb: begin
            if (item_i.right_edge && item_i.left_held) state_o.mode = wsmc_pkg::ModeHour;
            if (item_i.tap) begin
              case (state_i.phase)
                wsmc_pkg::PhIdle: begin
                  if (z_down) begin
                    state_o.phase = wsmc_pkg::PhFlip;
                    state_o.mode  = wsmc_pkg::ModeDeb;
                  end
                end
                wsmc_pkg::PhFlip: begin
                  if (z_up) begin
                    state_o.mode            = wsmc_pkg::ModeHour;
                    res_o.prolong_very_long = 1'b1;
                    state_o.phase           = wsmc_pkg::PhArmed;
                  end else begin
                    state_o.mode  = wsmc_pkg::ModeTime;
                    state_o.phase = wsmc_pkg::PhIdle;
                  end
                end
                default: ;
              endcase
              res_o.prolong_long = 1'b1;
            end
            wake_short = 1'b1;
          end
          wsmc_pkg::ModeHour: begin
            if (item_i.right_edge) state_o.mode = wsmc_pkg::ModeMin;
            if (item_i.tap) begin
              state_o.mode            = wsmc_pkg::ModeMin;
              res_o.prolong_very_long = 1'b1;
            end
            res_o.hour_change = {2'b00, item_i.left_edge};
            if (state_i.phase == wsmc_pkg::PhArmed) begin
              res_o.hour_change  = {2'b00, item_i.left_edge} + tilt_step;
              state_o.tilt_count = tilt_next;
            end
          end
          wsmc_pkg::ModeMin: begin
            if (item_i.right_edge) state_o.mode = wsmc_pkg::ModeTime;
            if (both_held) state_o.mode = wsmc_pkg::ModeCMin;
            if (item_i.tap) state_o.mode = z_down ? wsmc_pkg::ModeCMin : wsmc_pkg::ModeTime;
            res_o.minute_change = {2'b00, item_i.left_edge};
            if (state_i.phase == wsmc_pkg::PhArmed) begin
              res_o.minute_change = {2'b00, item_i.left_edge} + tilt_step;
              state_o.tilt_count  = tilt_next;
            end
          end
          wsmc_pkg::ModeCMin, wsmc_pkg::ModeCHour, wsmc_pkg::ModeCDay,
          wsmc_pkg::ModeCMon: begin
            state_o.corr[corr_idx] = corr_new;
            if (corr_adv) begin
              case (mode_cur)
                wsmc_pkg::ModeCMin:  state_o.mode = wsmc_pkg::ModeCHour;
                wsmc_pkg::ModeCHour: state_o.mode = wsmc_pkg::ModeCDay;
                wsmc_pkg::ModeCDay:  state_o.mode = wsmc_pkg::ModeCMon;
                default:             state_o.mode = wsmc_pkg::ModeTime;
              endcase
            end
          end
          default: begin
            state_o.mode = wsmc_pkg::ModeTime;
          end
        endcase
        if (any_held) begin
          if (wake_short) begin
            res_o.prolong_short = 1'b1;
          end else begin
            res_o.prolong_long = 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ src/watch_setting_mode_controller.sv @@
// Top level of the watch setting-mode controller: beat registers, state and configuration.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata: wake tick fields, tuser: req_type
//   m_axis    out        m_axis_tvalid/tready       tdata: one result per input beat
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// Each input beat is captured in an input register, evaluated by one short combinational
// step, and the result lands in an output register before it leaves on m_axis.
// One beat per cycle is sustained; the only limit is the output register draining.
// The mode, gesture and correction state updates when a beat moves into the output register.
// A stall on m_axis holds both registers and drops s_axis_tready once the input one is full.
// Reset (rst_ni low, asynchronous) returns state and configuration to their defaults.
module watch_setting_mode_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0 up: woken, right_edge, left_edge, right_held, left_held, tap,
  // accel_z[15:0], accel_y[15:0], then two zero bits.
  input  logic [wsmc_pkg::InDataW-1:0]       s_axis_tdata,
  // Fields from bit 0 up: req_type.
  input  logic                               s_axis_tuser,

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0 up: screen[3:0], shown_value[4:0], hour_change[2:0],
  // minute_change[2:0], prolong_short, prolong_long, prolong_very_long, acted,
  // then five zero bits.
  output logic [wsmc_pkg::OutDataW-1:0]      m_axis_tdata,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wsmc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wsmc_pkg::CfgDataW-1:0]      cfg_data_i
);

  // Input register holding the accepted beat.
  logic                 in_valid_q;
  wsmc_pkg::in_item_t   in_q;
  wsmc_pkg::in_item_t   in_d;

  // Output register holding the finished result.
  logic                 out_valid_q;
  wsmc_pkg::out_item_t  out_q;
  wsmc_pkg::out_item_t  out_d;

  // Controller state and configuration.
  wsmc_pkg::state_t     state_q, state_d;
  wsmc_pkg::cfg_t       cfg_q;

  logic                 advance;

  // A beat leaves the input register whenever the output register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_d.req_type   = s_axis_tuser;
    in_d.woken      = s_axis_tdata[0];
    in_d.right_edge = s_axis_tdata[1];
    in_d.left_edge  = s_axis_tdata[2];
    in_d.right_held = s_axis_tdata[3];
    in_d.left_held  = s_axis_tdata[4];
    in_d.tap        = s_axis_tdata[5];
    in_d.accel_z    = s_axis_tdata[21:6];
    in_d.accel_y    = s_axis_tdata[37:22];
  end

  wsmc_step u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= wsmc_pkg::ModeFade;
      state_q.input_enabled <= 1'b0;
      state_q.phase         <= wsmc_pkg::PhIdle;
      state_q.tilt_count    <= '0;
      state_q.corr          <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Writes to an index beyond the register list are taken and dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flip_th  <= wsmc_pkg::FlipThRst;
      cfg_q.tilt_th  <= wsmc_pkg::TiltThRst;
      cfg_q.tilt_lim <= wsmc_pkg::TiltLimRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wsmc_pkg::CfgFlipTh:  cfg_q.flip_th  <= cfg_data_i[wsmc_pkg::ThW-1:0];
        wsmc_pkg::CfgTiltTh:  cfg_q.tilt_th  <= cfg_data_i[wsmc_pkg::ThW-1:0];
        wsmc_pkg::CfgTiltLim: cfg_q.tilt_lim <= cfg_data_i[wsmc_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000,
                          out_q.acted,
                          out_q.prolong_very_long,
                          out_q.prolong_long,
                          out_q.prolong_short,
                          out_q.minute_change,
                          out_q.hour_change,
                          out_q.shown_value,
                          out_q.screen};

endmodule

@@ verif/watch_setting_mode_controller_tb.sv @@
// Self-checking testbench for the watch setting-mode controller: directed and random beats.
module watch_setting_mode_controller_tb;

  // Clock, reset and the three channels of the block.
  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // Fields from bit 0 up: woken, right_edge, left_edge, right_held, left_held, tap,
  // accel_z[15:0], accel_y[15:0], two zero bits.
  logic [wsmc_pkg::InDataW-1:0]  s_axis_tdata;
  // Fields from bit 0 up: req_type.
  logic                          s_axis_tuser;

  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // Fields from bit 0 up: screen, shown_value, hour_change, minute_change,
  // prolong_short, prolong_long, prolong_very_long, acted, five zero bits.
  logic [wsmc_pkg::OutDataW-1:0] m_axis_tdata;

  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [wsmc_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [wsmc_pkg::CfgDataW-1:0] cfg_data_i;

  watch_setting_mode_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The run is short in practice; this bound only catches a hung handshake.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Our own copy of the watch UI: settings, mode, gesture and corrections.
  // The mode is held as its screen code, which is how the result reports it.
  // ---------------------------------------------------------------------------
  int                         flip_th  = int'(wsmc_pkg::FlipThRst);
  int                         tilt_th  = int'(wsmc_pkg::TiltThRst);
  int                         tilt_lim = int'(wsmc_pkg::TiltLimRst);

  logic [3:0]                 ui_code  = wsmc_pkg::ScrFade;
  bit                         inputs_on = 1'b0;
  wsmc_pkg::phase_e           gesture  = wsmc_pkg::PhIdle;
  int                         tilt_cnt = 0;
  logic [wsmc_pkg::CorrW-1:0] corr_vals [4] = '{default: '0};

  // Screen reports that have been earned by accepted beats but not yet seen.
  wsmc_pkg::out_item_t        due_reports [$];
  int                         bad_fields = 0;
  int                         ui_items   = 0;

  // Per-sequence switches that turn off idling on one side for a stretch.
  bit                         src_quiet  = 1'b0;
  bit                         sink_quiet = 1'b0;
  int                         stall_left = 0;

  // One step of the tilt gesture; the Y axis is negated with saturation so that
  // the most negative sample reads as the largest positive tilt.
  function automatic int tilt_step(logic signed [15:0] y);
    int mag;
    mag = (int'(y) == -32768) ? 32767 : -int'(y);
    if (mag > tilt_th) tilt_cnt++;
    else if (mag < -tilt_th) tilt_cnt--;
    else tilt_cnt = 0;
    if (tilt_cnt > tilt_lim) begin
      tilt_cnt = 0;
      return 1;
    end
    if (tilt_cnt < -tilt_lim) begin
      tilt_cnt = 0;
      return -1;
    end
    return 0;
  endfunction

  // Edit one correction value. The right edge counts down and the left edge up, both
  // wrapping at the maximum. With both buttons held an edge moves on to the next
  // screen, and once the right edge does so the left edge of that tick is dropped.
  function automatic bit edit_correction(int k, logic [wsmc_pkg::CorrW-1:0] maxv,
                                         bit re, bit le, bit rh, bit lh);
    if (re) begin
      corr_vals[k] = (corr_vals[k] == '0) ? maxv : corr_vals[k] - 1'b1;
      if (lh && rh) return 1'b1;
    end
    if (le) begin
      corr_vals[k] = (corr_vals[k] == maxv) ? '0 : corr_vals[k] + 1'b1;
      if (lh && rh) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the screen report for one beat and advances the UI state.
  function automatic wsmc_pkg::out_item_t run_ui_step(wsmc_pkg::in_item_t it);
    wsmc_pkg::out_item_t r;
    bit                  wake_short;
    int                  hc;
    int                  mc;
    int                  k;
    r          = '0;
    r.screen   = wsmc_pkg::ScrEmpty;
    wake_short = 1'b0;
    hc         = 0;
    mc         = 0;
    if (it.req_type) begin
      // Going to sleep: back to fade-in, buttons locked until both are released.
      ui_code   = wsmc_pkg::ScrFade;
      inputs_on = 1'b0;
      gesture   = wsmc_pkg::PhIdle;
      r.acted   = 1'b1;
    end else if (it.woken) begin
      r.acted  = 1'b1;
      r.screen = (ui_code < wsmc_pkg::ScrEmpty) ? ui_code : wsmc_pkg::ScrEmpty;
      if (ui_code >= wsmc_pkg::ScrCMin && ui_code <= wsmc_pkg::ScrCMon)
        r.shown_value = corr_vals[int'(ui_code - wsmc_pkg::ScrCMin)];
      if (ui_code == wsmc_pkg::ScrFade) begin
        ui_code = wsmc_pkg::ScrTime;
        r.prolong_short = 1'b1;
      end
      if (!inputs_on && !it.right_held && !it.left_held) inputs_on = 1'b1;
      if (inputs_on) begin
        case (ui_code)
          wsmc_pkg::ScrTime, wsmc_pkg::ScrDeb: begin
            if (it.right_edge && it.left_held) ui_code = wsmc_pkg::ScrHour;
            if (it.tap) begin
              // Face down, then face up, arms the tilt gesture for setting the time.
              if (gesture == wsmc_pkg::PhIdle) begin
                if (int'(it.accel_z) < -flip_th) begin
                  gesture = wsmc_pkg::PhFlip;
                  ui_code = wsmc_pkg::ScrDeb;
                end
              end else if (gesture == wsmc_pkg::PhFlip) begin
                if (int'(it.accel_z) > flip_th) begin
                  ui_code = wsmc_pkg::ScrHour;
                  r.prolong_very_long = 1'b1;
                  gesture = wsmc_pkg::PhArmed;
                end else begin
                  ui_code = wsmc_pkg::ScrTime;
                  gesture = wsmc_pkg::PhIdle;
                end
              end
              r.prolong_long = 1'b1;
            end
            wake_short = 1'b1;
          end
          wsmc_pkg::ScrHour: begin
            if (it.left_edge) hc++;
            if (it.right_edge) ui_code = wsmc_pkg::ScrMin;
            if (it.tap) begin
              ui_code = wsmc_pkg::ScrMin;
              r.prolong_very_long = 1'b1;
            end
            if (gesture == wsmc_pkg::PhArmed) hc += tilt_step(it.accel_y);
          end
          wsmc_pkg::ScrMin: begin
            if (it.left_edge) mc++;
            if (it.right_edge) ui_code = wsmc_pkg::ScrTime;
            if (it.left_held && it.right_held) ui_code = wsmc_pkg::ScrCMin;
            if (it.tap)
              ui_code = (int'(it.accel_z) < -flip_th) ? wsmc_pkg::ScrCMin : wsmc_pkg::ScrTime;
            if (gesture == wsmc_pkg::PhArmed) mc += tilt_step(it.accel_y);
          end
          wsmc_pkg::ScrCMin, wsmc_pkg::ScrCHour, wsmc_pkg::ScrCDay,
          wsmc_pkg::ScrCMon: begin
            k = int'(ui_code - wsmc_pkg::ScrCMin);
            if (edit_correction(k, (ui_code == wsmc_pkg::ScrCDay) ? wsmc_pkg::DayCorrMax
                                                                  : wsmc_pkg::CorrMax,
                                it.right_edge, it.left_edge, it.right_held, it.left_held))
              ui_code = (ui_code == wsmc_pkg::ScrCMon) ? wsmc_pkg::ScrTime : ui_code + 1'b1;
          end
          default: ui_code = wsmc_pkg::ScrTime;
        endcase
        if (it.right_held || it.left_held) begin
          if (wake_short) r.prolong_short = 1'b1;
          else r.prolong_long = 1'b1;
        end
      end
      r.hour_change   = hc[2:0];
      r.minute_change = mc[2:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, wanted %0d", $realtime, what, got, want);
    bad_fields++;
  endtask

  always @(posedge clk_i) begin
    wsmc_pkg::out_item_t got;
    wsmc_pkg::out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.screen            = m_axis_tdata[3:0];
      got.shown_value       = m_axis_tdata[8:4];
      got.hour_change       = m_axis_tdata[11:9];
      got.minute_change     = m_axis_tdata[14:12];
      got.prolong_short     = m_axis_tdata[15];
      got.prolong_long      = m_axis_tdata[16];
      got.prolong_very_long = m_axis_tdata[17];
      got.acted             = m_axis_tdata[18];
      if (due_reports.size() == 0) begin
        report_mismatch("unrequested result beat, screen", int'(got.screen), -1);
      end else begin
        want = due_reports.pop_front();
        if (got.screen != want.screen)
          report_mismatch("screen", int'(got.screen), int'(want.screen));
        if (got.shown_value != want.shown_value)
          report_mismatch("shown_value", int'(got.shown_value), int'(want.shown_value));
        if (got.hour_change != want.hour_change)
          report_mismatch("hour_change", int'(got.hour_change), int'(want.hour_change));
        if (got.minute_change != want.minute_change)
          report_mismatch("minute_change", int'(got.minute_change),
                          int'(want.minute_change));
        if (got.prolong_short != want.prolong_short)
          report_mismatch("prolong_short", int'(got.prolong_short),
                          int'(want.prolong_short));
        if (got.prolong_long != want.prolong_long)
          report_mismatch("prolong_long", int'(got.prolong_long),
                          int'(want.prolong_long));
        if (got.prolong_very_long != want.prolong_very_long)
          report_mismatch("prolong_very_long", int'(got.prolong_very_long),
                          int'(want.prolong_very_long));
        if (got.acted != want.acted)
          report_mismatch("acted", int'(got.acted), int'(want.acted));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random helpers.
  // ---------------------------------------------------------------------------
  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Mostly back-to-back, often a few cycles, now and then a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The result side stalls at random unless a quiet stretch is running.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_quiet && chance(30)) stall_left = gap_len();
    end
  end

  // An axis sample strictly beyond the threshold on one side. The positive side does
  // not exist for the top threshold, so the largest sample stands in for it.
  function automatic logic signed [15:0] axis_beyond(int th, bit neg);
    int mag;
    if (!neg && th >= 32767) return 16'sh7fff;
    if (neg) mag = chance(25) ? th + 1 : $urandom_range(th + 1, 32768);
    else mag = chance(25) ? th + 1 : $urandom_range(th + 1, 32767);
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  // An axis sample biased toward the extremes and the edges of the threshold band.
  function automatic logic signed [15:0] pick_axis(int th);
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = th;
      3:       v = -th;
      4:       v = 0;
      5, 6:    v = int'(axis_beyond(th, 1'b0));
      7:       v = int'(axis_beyond(th, 1'b1));
      default: v = $urandom_range(0, 65535);
    endcase
    return 16'(v);
  endfunction

  function automatic wsmc_pkg::in_item_t wake_tick(bit re, bit le, bit rh, bit lh, bit tap,
                                                   logic signed [15:0] z,
                                                   logic signed [15:0] y);
    wsmc_pkg::in_item_t it;
    it            = '0;
    it.woken      = 1'b1;
    it.right_edge = re;
    it.left_edge  = le;
    it.right_held = rh;
    it.left_held  = lh;
    it.tap        = tap;
    it.accel_z    = z;
    it.accel_y    = y;
    return it;
  endfunction

  function automatic wsmc_pkg::in_item_t sleep_event();
    wsmc_pkg::in_item_t it;
    it          = '0;
    it.req_type = 1'b1;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: one input beat, the settle wait and the register writes.
  // ---------------------------------------------------------------------------
  task automatic send_item(input wsmc_pkg::in_item_t it);
    int gap;
    gap = src_quiet ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.accel_y, it.accel_z, it.tap, it.left_held,
                      it.right_held, it.left_edge, it.right_edge, it.woken};
    s_axis_tuser  <= it.req_type;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    due_reports.push_back(run_ui_step(it));
    if (it.req_type || it.woken) ui_items++;
    @(negedge clk_i);
  endtask

  // Lets every owed result come out, then waits out the two-stage pipeline.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic apply_settings(int flip, int tilt, int lim);
    logic [wsmc_pkg::CfgIdxW-1:0]  idx [3];
    logic [wsmc_pkg::CfgDataW-1:0] val [3];
    int k;
    idx[0] = wsmc_pkg::CfgFlipTh;
    idx[1] = wsmc_pkg::CfgTiltTh;
    idx[2] = wsmc_pkg::CfgTiltLim;
    val[0] = wsmc_pkg::CfgDataW'(flip);
    val[1] = wsmc_pkg::CfgDataW'(tilt);
    val[2] = wsmc_pkg::CfgDataW'(lim);
    settle();
    for (k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    flip_th  = flip;
    tilt_th  = tilt;
    tilt_lim = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequences.
  // ---------------------------------------------------------------------------

  // A run of ticks tilted one way, the limit or up to three longer: when armed, a run
  // past the limit fires one step, and a rare wobble back into the band restarts the count.
  task automatic tilt_streak();
    int                 n;
    bit                 neg;
    logic signed [15:0] y;
    n   = tilt_lim + $urandom_range(0, 3);
    if (n > 110) n = 110;
    neg = chance(50);
    repeat (n) begin
      y = chance(3) ? pick_axis(tilt_th) : axis_beyond(tilt_th, neg);
      send_item(wake_tick(1'b0, chance(10), 1'b0, 1'b0, 1'b0, pick_axis(flip_th), y));
    end
  endtask

  // Sleep, wake, face down, face up, then tilt hours and maybe minutes.
  task automatic gesture_run();
    logic signed [15:0] z_up;
    send_item(sleep_event());
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, pick_axis(flip_th),
                        pick_axis(tilt_th)));
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, axis_beyond(flip_th, 1'b1),
                        pick_axis(tilt_th)));
    z_up = chance(15) ? pick_axis(flip_th) : axis_beyond(flip_th, 1'b0);
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, z_up, pick_axis(tilt_th)));
    tilt_streak();
    if (chance(75)) begin
      // A tap in the hour screen moves on to minutes.
      send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, pick_axis(flip_th),
                          pick_axis(tilt_th)));
      tilt_streak();
    end
  endtask

  // Button-heavy ticks that walk through hour, minute and correction screens.
  task automatic button_run();
    repeat ($urandom_range(5, 20))
      send_item(wake_tick(chance(30), chance(30), chance(35), chance(35), chance(10),
                          pick_axis(flip_th), pick_axis(tilt_th)));
  endtask

  // Fully random beats, sleep events and idle ticks among them.
  task automatic noise_run();
    wsmc_pkg::in_item_t it;
    repeat ($urandom_range(3, 10)) begin
      it          = wsmc_pkg::in_item_t'({$urandom(), $urandom()});
      it.req_type = chance(8);
      it.woken    = chance(85);
      send_item(it);
    end
  endtask

  task automatic random_phase(int n);
    int stop;
    int r;
    stop = ui_items + n;
    while (ui_items < stop) begin
      src_quiet  = chance(15);
      sink_quiet = chance(15);
      r = $urandom_range(0, 99);
      if (r < 40) gesture_run();
      else if (r < 75) button_run();
      else noise_run();
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Walks every screen by hand with the reset settings, including the wraps of the
  // correction values, the flip gesture both ways and the saturating Y negation.
  task automatic test_directed();
    // An idle tick with every other field at its extreme.
    send_item(wsmc_pkg::in_item_t'({1'b0, 1'b0, 5'b11111, 16'sh8000, 16'sh7fff}));
    send_item(sleep_event());
    // A held button keeps input locked, but fade-in still moves to time.
    send_item(wake_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7fff, 16'sh8000));
    // Right edge with left held goes to the hour screen.
    send_item(wake_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    // Minute screen: step, and both held opens the correction screens.
    send_item(wake_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    // Right edge with both held wraps 0 down to the maximum, advances, drops left.
    send_item(wake_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    // Up from the maximum wraps to 0.
    send_item(wake_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    // Per-day screen has the smaller maximum.
    send_item(wake_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    // The last correction screen returns to time.
    send_item(wake_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh0000));
    // Flip gesture: face down, then face up arms the tilt.
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh8000, 16'sh0000));
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh7fff, 16'sh0000));
    // Most negative Y tilts forward; the tap moves on to minutes.
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh0000, 16'sh8000));
    // Tap while face down goes straight to correction screens.
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh8000, 16'sh7fff));
    send_item(sleep_event());
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000));
    // Face down, then a tap that is not face up drops the gesture.
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh8000, 16'sh0000));
    send_item(wake_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'sh0000, 16'sh0000));
    send_item(wake_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'sh0000, 16'sh7fff));
  endtask

  task automatic test_default_settings();
    random_phase(200);
  endtask

  // Zero thresholds and a limit of one: any tap with Z off zero can flip, and tilts fire quickly.
  task automatic test_low_thresholds();
    apply_settings(0, 0, 1);
    random_phase(120);
  endtask

  // Top thresholds and a limit of 100: face up and tilts can no longer be met.
  task automatic test_high_thresholds();
    apply_settings(32767, 32767, 100);
    random_phase(80);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                     $urandom_range(1, 12));
      random_phase(40);
    end
    apply_settings(int'(wsmc_pkg::FlipThRst), int'(wsmc_pkg::TiltThRst),
                   int'(wsmc_pkg::TiltLimRst));
    random_phase(40);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = wsmc_pkg::CfgFlipTh;
    cfg_data_i    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_default_settings();
    test_low_thresholds();
    test_high_thresholds();
    test_random_settings();

    settle();
    if (due_reports.size() != 0)
      report_mismatch("results never delivered", due_reports.size(), 0);
    if (bad_fields == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
